FILE: hdl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, constants and the pattern ROM of the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int PAT_W        = 3;
    localparam int STEP_W       = 3;
    localparam int TICK_W       = 11;
    localparam int NUM_PATTERNS = 7;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_STOP = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef enum logic [PAT_W-1:0] {
        PAT_NONE   = 3'd0,
        PAT_OPEN   = 3'd1,
        PAT_CLOSE  = 3'd2,
        PAT_FAULT  = 3'd3,
        PAT_ESTOP  = 3'd4,
        PAT_CLOSED = 3'd5,
        PAT_READY  = 3'd6
    } t_pat;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [STEP_W-1:0] step;
        logic [TICK_W-1:0] ticks;
        logic              level;
    } t_state;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] dur;
    } t_tone;

    function automatic logic [STEP_W-1:0] step_total(input logic [PAT_W-1:0] pat);
        logic [STEP_W-1:0] total;
        case (pat)
            PAT_OPEN:   total = 3'd3;
            PAT_CLOSE:  total = 3'd1;
            PAT_FAULT:  total = 3'd5;
            PAT_ESTOP:  total = 3'd1;
            PAT_CLOSED: total = 3'd1;
            PAT_READY:  total = 3'd3;
            default:    total = 3'd0;
        endcase
        return total;
    endfunction

    function automatic t_tone step_tone(input logic [PAT_W-1:0] pat,
                                        input logic [STEP_W-1:0] step);
        t_tone tone;
        tone = '0;
        case (pat)
            PAT_OPEN: begin
                case (step)
                    3'd0:    tone = '{1'b1, 11'd80};
                    3'd1:    tone = '{1'b0, 11'd80};
                    3'd2:    tone = '{1'b1, 11'd80};
                    default: tone = '0;
                endcase
            end
            PAT_CLOSE: begin
                if (step == 3'd0) begin
                    tone = '{1'b1, 11'd400};
                end
            end
            PAT_FAULT: begin
                case (step)
                    3'd0, 3'd2, 3'd4: tone = '{1'b1, 11'd60};
                    3'd1, 3'd3:       tone = '{1'b0, 11'd60};
                    default:          tone = '0;
                endcase
            end
            PAT_ESTOP: begin
                if (step == 3'd0) begin
                    tone = '{1'b1, 11'd1200};
                end
            end
            PAT_CLOSED: begin
                if (step == 3'd0) begin
                    tone = '{1'b1, 11'd60};
                end
            end
            PAT_READY: begin
                case (step)
                    3'd0, 3'd2: tone = '{1'b1, 11'd40};
                    3'd1:       tone = '{1'b0, 11'd60};
                    default:    tone = '0;
                endcase
            end
            default: tone = '0;
        endcase
        return tone;
    endfunction

endpackage

FILE: hdl/bps_step_ctrl.sv
// ----------------------------------------------------------------------------
// bps_step_ctrl
// Next-state logic: applies one event to the sequencer state.
// ----------------------------------------------------------------------------
module bps_step_ctrl #(
    parameter int NUM_PATTERNS = bps_pkg::NUM_PATTERNS
) (
    input  bps_pkg::t_state              i_state,
    input  logic [1:0]                   i_operation,
    input  logic [bps_pkg::PAT_W-1:0]    i_pattern_id,
    input  logic                         i_direct_level,
    output bps_pkg::t_state              o_state
);

    localparam logic [bps_pkg::PAT_W:0] NUM_PAT_C = (bps_pkg::PAT_W+1)'(NUM_PATTERNS);

    logic [bps_pkg::STEP_W-1:0] next_step;
    bps_pkg::t_tone             adv_tone;
    bps_pkg::t_tone             play_tone;
    logic [bps_pkg::STEP_W-1:0] play_total;

    assign next_step  = i_state.step + 1'b1;
    assign adv_tone   = bps_pkg::step_tone(i_state.pattern, next_step);
    assign play_tone  = bps_pkg::step_tone(i_pattern_id, '0);
    assign play_total = bps_pkg::step_total(i_pattern_id);

    always_comb begin
        o_state = i_state;
        case (bps_pkg::t_op'(i_operation))
            bps_pkg::OP_TICK: begin
                if (i_state.pattern != bps_pkg::PAT_NONE) begin
                    if (i_state.ticks != '0) begin
                        o_state.ticks = i_state.ticks - 1'b1;
                    end else if (next_step >= bps_pkg::step_total(i_state.pattern)) begin
                        o_state = '0;
                    end else begin
                        o_state.step  = next_step;
                        o_state.ticks = adv_tone.dur;
                        o_state.level = adv_tone.level;
                    end
                end
            end
            bps_pkg::OP_PLAY: begin
                if ({1'b0, i_pattern_id} < NUM_PAT_C) begin
                    if (play_total == '0) begin
                        o_state = '0;
                    end else begin
                        o_state.pattern = i_pattern_id;
                        o_state.step    = '0;
                        o_state.ticks   = play_tone.dur;
                        o_state.level   = play_tone.level;
                    end
                end
            end
            bps_pkg::OP_STOP: begin
                o_state = '0;
            end
            bps_pkg::OP_SET: begin
                o_state       = '0;
                o_state.level = i_direct_level;
            end
            default: o_state = i_state;
        endcase
    end

endmodule

FILE: hdl/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Non-blocking buzzer driver that walks fixed tone patterns on tick events.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------------------
//  event in | i_valid / o_stall    | i_operation, i_pattern_id, i_direct_level
//  result   | o_valid / i_stall    | o_pin_level, o_sounding, o_busy_res
//  config   | i_cfg_we             | i_cfg_wdata (pin polarity)
//
// Each word is applied to the state in the cycle it is accepted and its result
// appears in the output register in the next cycle. One word per cycle is taken
// whenever the output register is empty or being drained. Reset clears the
// pattern state, the level and the output valid and sets the polarity to
// active high. A stall holds the result and stalls the event input.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer #(
    parameter int NUM_PATTERNS = bps_pkg::NUM_PATTERNS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_operation,
    input  logic [bps_pkg::PAT_W-1:0] i_pattern_id,
    input  logic                      i_direct_level,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_pin_level,
    output logic                      o_sounding,
    output logic                      o_busy_res
);

    bps_pkg::t_state r_state;
    bps_pkg::t_state n_state;
    logic            r_pin_active_high;
    logic            r_out_valid;
    logic            r_pin_level;
    logic            r_sounding;
    logic            r_busy;
    logic            in_take;

    assign o_stall = r_out_valid & i_stall;
    assign in_take = i_valid & ~o_stall;

    bps_step_ctrl #(
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_step_ctrl (
        .i_state        (r_state),
        .i_operation    (i_operation),
        .i_pattern_id   (i_pattern_id),
        .i_direct_level (i_direct_level),
        .o_state        (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= '0;
            r_pin_active_high <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pin_active_high <= i_cfg_wdata;
            end
            if (in_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pin_level <= r_pin_active_high ? n_state.level : ~n_state.level;
            r_sounding  <= n_state.level;
            r_busy      <= (n_state.pattern != bps_pkg::PAT_NONE);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pin_level = r_pin_level;
    assign o_sounding  = r_sounding;
    assign o_busy_res  = r_busy;

    a_busy_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_busy_res == (r_state.pattern != bps_pkg::PAT_NONE)))
        else $error("busy flag disagrees with the running pattern");

    a_idle_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pattern == bps_pkg::PAT_NONE) |-> (r_state.step == '0 && r_state.ticks == '0))
        else $error("idle state holds a step or a count");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pattern != bps_pkg::PAT_NONE)
            |-> (r_state.step < bps_pkg::step_total(r_state.pattern)))
        else $error("step position beyond the end of the pattern");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_valid)
        else $error("accepted word produced no result");

endmodule
